// ----- rtl/sfsp_pkg.sv -----
// Shared constants for the sensor frame sync parser.
`timescale 1ns / 1ps

package sfsp_pkg;

  localparam logic [7:0]  HDR_FIRST   = 8'h42;
  localparam logic [7:0]  HDR_SECOND  = 8'h4D;
  localparam logic [15:0] SUM_BIAS    = 16'h0406;
  localparam logic [15:0] SUM_SEED    = SUM_BIAS + 16'(HDR_FIRST) + 16'(HDR_SECOND);

  localparam int          POS_W       = 4;
  localparam logic [3:0]  POS_HUNT    = 4'd0;
  localparam logic [3:0]  POS_HDR2    = 4'd1;
  localparam logic [3:0]  POS_FIRST   = 4'd2;
  localparam logic [3:0]  POS_WORD_LO = 4'd2;
  localparam logic [3:0]  POS_WORD_HI = 4'd11;
  localparam logic [3:0]  POS_SUM_END = 4'd13;
  localparam logic [3:0]  POS_RX_HI   = 4'd14;
  localparam logic [3:0]  POS_LAST    = 4'd15;

  localparam int          OUT_BITS    = 113;
  localparam int          OUT_TDATA_W = 120;

endpackage

// ----- rtl/sensor_frame_sync_parser_top.sv -----
// Top level: frame sync, byte capture and checksum for a 16-byte sensor frame.
`timescale 1ns / 1ps

// Takes one received byte per cycle on the input stream and hunts for the header 0x42 0x4D; a
// repeated 0x42 after the first keeps the hunt one byte in. Once in frame, payload bytes go into
// position registers and a running 16-bit sum; each byte takes a position update, a store and
// one add into the sum. The byte that completes the frame loads one result word into the
// output register, and the parser returns to hunting. A new byte is taken every cycle, also while
// a result waits, except that the closing byte of the next frame waits until the output register
// is free. A result is emitted whether or not the checksum matches; checksum_ok tells which.
module sensor_frame_sync_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // [15:0] co2_ppm, [31:16] temp_raw, [47:32] humidity_raw,
                                   // [63:48] calib_days, [79:64] status_word,
                                   // [95:80] sum_received, [111:96] sum_computed,
                                   // [112] checksum_ok, [119:113] zero
);

  logic [sfsp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]                sum_r, sum_nxt;
  logic [7:0]                 byte_r [sfsp_pkg::POS_WORD_LO:sfsp_pkg::POS_WORD_HI];
  logic [7:0]                 rx_hi_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [sfsp_pkg::OUT_BITS-1:0] out_data_r;
  logic                       in_acc;
  logic                       frame_done;
  logic [15:0]                rx_sum;

  assign in_tready  = !out_valid_r || (pos_r != sfsp_pkg::POS_LAST);
  assign in_acc     = in_tvalid && in_tready;
  assign frame_done = in_acc && (pos_r == sfsp_pkg::POS_LAST);
  assign rx_sum     = {rx_hi_r, in_tdata};

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (in_acc) begin
      case (pos_r)
        sfsp_pkg::POS_HUNT: begin
          if (in_tdata == sfsp_pkg::HDR_FIRST) pos_nxt = sfsp_pkg::POS_HDR2;
        end
        sfsp_pkg::POS_HDR2: begin
          if (in_tdata == sfsp_pkg::HDR_SECOND) begin
            pos_nxt = sfsp_pkg::POS_FIRST;
            sum_nxt = sfsp_pkg::SUM_SEED;
          end else if (in_tdata == sfsp_pkg::HDR_FIRST) begin
            pos_nxt = sfsp_pkg::POS_HDR2;
          end else begin
            pos_nxt = sfsp_pkg::POS_HUNT;
          end
        end
        sfsp_pkg::POS_LAST: begin
          pos_nxt = sfsp_pkg::POS_HUNT;
        end
        default: begin
          pos_nxt = pos_r + 4'd1;
          if (pos_r <= sfsp_pkg::POS_SUM_END) sum_nxt = sum_r + 16'(in_tdata);
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= sfsp_pkg::POS_HUNT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (in_acc && pos_r >= sfsp_pkg::POS_WORD_LO && pos_r <= sfsp_pkg::POS_WORD_HI) begin
      byte_r[pos_r] <= in_tdata;
    end
    if (in_acc && pos_r == sfsp_pkg::POS_RX_HI) begin
      rx_hi_r <= in_tdata;
    end
    if (frame_done) begin
      out_data_r <= {(rx_sum == sum_r), sum_r, rx_sum,
                     byte_r[10], byte_r[11], byte_r[8], byte_r[9],
                     byte_r[6], byte_r[7], byte_r[4], byte_r[5],
                     byte_r[2], byte_r[3]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(sfsp_pkg::OUT_TDATA_W - sfsp_pkg::OUT_BITS)'(0), out_data_r};

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && pos_r == sfsp_pkg::POS_LAST))
    else $error("result appeared without a closing frame byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(frame_done && out_valid_r && !out_tready))
    else $error("closing byte accepted while result register was full");

  a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[112] == (out_tdata[95:80] == out_tdata[111:96])))
    else $error("checksum flag disagrees with checksum words");

  a_hunt_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> pos_r == sfsp_pkg::POS_HUNT)
    else $error("parser did not return to hunting after a frame");

endmodule
